@@ hw/rtl/lunp_pkg.sv @@
package lunp_pkg;

    // Label bytes taken from each entry and their size in bits
    localparam int unsigned LABEL_BYTES = 3;
    localparam logic [7:0]  LABEL_BITS  = 8'(LABEL_BYTES * 8);
    localparam int unsigned IPV4_BYTES  = 4;

    localparam logic CFG_ADDR_FAMILY = 1'b0;
    localparam logic CFG_SESSION     = 1'b1;

    typedef enum logic [2:0] {
        KIND_ANNOUNCE  = 3'd0,
        KIND_WITHDRAW  = 3'd1,
        KIND_DROPPED   = 3'd2,
        KIND_PACKET_OK = 3'd3,
        KIND_SHORT     = 3'd4,
        KIND_OVERRUN   = 3'd5,
        KIND_IGNORED   = 3'd6
    } t_kind;

    typedef enum logic {
        PH_LEN  = 1'b0,
        PH_BODY = 1'b1
    } t_phase;

    typedef enum logic [1:0] {
        ERR_NONE    = 2'd0,
        ERR_SHORT   = 2'd1,
        ERR_IGNORED = 2'd2
    } t_err;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_update;
        logic       last_byte;
    } t_in_beat;

    typedef struct packed {
        t_kind        kind;
        logic [23:0]  route_label;
        logic [7:0]   prefix_bits;
        logic [63:0]  prefix_high;
        logic [63:0]  prefix_low;
        logic         final_result;
    } t_out_beat;

endpackage

@@ hw/rtl/lunp_res_q.sv @@
module lunp_res_q (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [1:0]        i_push_cnt,
    input  lunp_pkg::t_out_beat i_res0,
    input  lunp_pkg::t_out_beat i_res1,
    output logic              o_can_take,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output lunp_pkg::t_out_beat o_out
);
    import lunp_pkg::*;

    t_out_beat r_q0, r_q1, r_q2;
    t_out_beat n_q0, n_q1, n_q2;
    logic [1:0] r_fill, n_fill;
    logic       w_pop;
    logic [1:0] w_base;

    assign w_pop       = (r_fill != 2'd0) && !i_out_stall;
    assign w_base      = r_fill - {1'b0, w_pop};
    // room for two results is kept free before a beat is taken
    assign o_can_take  = (r_fill <= 2'd1);
    assign o_out_valid = (r_fill != 2'd0);
    assign o_out       = r_q0;

    always_comb begin
        n_q0 = w_pop ? r_q1 : r_q0;
        n_q1 = w_pop ? r_q2 : r_q1;
        n_q2 = r_q2;
        if (i_push_cnt != 2'd0) begin
            case (w_base)
                2'd0:    n_q0 = i_res0;
                2'd1:    n_q1 = i_res0;
                default: n_q2 = i_res0;
            endcase
        end
        if (i_push_cnt == 2'd2) begin
            case (w_base)
                2'd0:    n_q1 = i_res1;
                default: n_q2 = i_res1;
            endcase
        end
        n_fill = w_base + i_push_cnt;
    end

    always_ff @(posedge i_clk) begin
        r_q0 <= n_q0;
        r_q1 <= n_q1;
        r_q2 <= n_q2;
        if (!i_rst_n) begin
            r_fill <= 2'd0;
        end else begin
            r_fill <= n_fill;
        end
    end

endmodule

@@ hw/rtl/labeled_unicast_nlri_parser_core.sv @@
// Labelled-unicast NLRI parser.
// Input channel (i_in_valid / o_in_stall, payload i_in): one NLRI byte per
// beat with the update flag and a last-byte mark. Output channel
// (o_out_valid / i_out_stall, payload o_out): one route, dropped-entry report
// or packet status per beat; final_result marks the last beat caused by one
// input byte. Configuration (i_cfg_valid / o_cfg_ready): index 0 is the
// address family, index 1 the session-up flag; ready is always high and
// writes are expected only while the block is idle.
// Throughput: one input byte per cycle while the result queue has room, set
// by the single parse step between the input handshake and the result queue.
// Each result is registered in the queue before it is offered. A byte that
// completes an entry and ends the packet yields two beats; the second one
// holds the input off until the downstream side takes a beat.
// The three-deep result queue lets a byte be taken while a result still waits;
// a stalled receiver fills it and the input then stalls.
// Reset (synchronous, active low) empties the queue, clears both registers and
// returns the parser to expecting a length byte. No clearing pass is needed.
module labeled_unicast_nlri_parser_core #(
    parameter int unsigned MAX_PREFIX_BYTES = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  lunp_pkg::t_in_beat  i_in,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output lunp_pkg::t_out_beat o_out,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic                i_cfg_index,
    input  logic                i_cfg_data
);
    import lunp_pkg::*;

    // configuration
    logic r_af, r_sess;

    // parse state
    t_phase r_phase, n_phase;
    t_err   r_err, n_err;
    logic [7:0]  r_len, n_len;
    logic [5:0]  r_seen, n_seen;
    logic [23:0] r_label, n_label;
    logic [MAX_PREFIX_BYTES-1:0][7:0] r_pfx, n_pfx;

    logic        w_take, w_can_take;
    logic [1:0]  w_push_cnt;
    t_out_beat   w_res0, w_res1;
    t_out_beat   w_route, w_status;
    t_err        w_err_in;
    logic [5:0]  w_psize, w_pbytes, w_fam, w_p;
    logic [7:0]  w_bits;
    logic        w_done;
    logic [127:0] w_pfx_wide;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = !w_can_take;
    assign w_take      = i_in_valid && w_can_take;

    // prefix size in bytes, label included, and the family limit
    assign w_psize  = 6'((9'(r_len) + 9'd7) >> 3);
    assign w_pbytes = w_psize - 6'(LABEL_BYTES);
    assign w_fam    = r_af ? 6'(MAX_PREFIX_BYTES) : 6'(IPV4_BYTES);
    assign w_p      = r_seen - 6'(LABEL_BYTES);
    assign w_bits   = r_len - LABEL_BITS;

    always_comb begin
        n_phase  = r_phase;
        n_err    = r_err;
        n_len    = r_len;
        n_seen   = r_seen;
        n_label  = r_label;
        n_pfx    = r_pfx;
        w_done   = 1'b0;
        w_err_in = (!r_sess && r_err == ERR_NONE) ? ERR_IGNORED : r_err;
        n_err    = w_err_in;

        if (w_err_in == ERR_NONE) begin
            if (r_phase == PH_LEN) begin
                if (i_in.data_byte < LABEL_BITS) begin
                    n_err = ERR_SHORT;
                end else begin
                    n_len   = i_in.data_byte;
                    n_seen  = 6'd0;
                    n_label = '0;
                    n_pfx   = '0;
                    n_phase = PH_BODY;
                end
            end else begin
                if (r_seen < 6'(LABEL_BYTES)) begin
                    n_label = {r_label[15:0], i_in.data_byte};
                end else begin
                    for (int i = 0; i < MAX_PREFIX_BYTES; i++) begin
                        if (w_p == 6'(i)) begin
                            n_pfx[i] = i_in.data_byte;
                        end
                    end
                end
                n_seen = r_seen + 6'd1;
                w_done = (7'(r_seen) + 7'd1) >= 7'(w_psize);
            end
        end

        // left-align the prefix bytes, zero beyond the stored depth
        w_pfx_wide = '0;
        for (int i = 0; i < MAX_PREFIX_BYTES; i++) begin
            w_pfx_wide[127 - 8*i -: 8] = n_pfx[i];
        end

        w_route.route_label  = n_label;
        w_route.prefix_bits  = w_bits;
        w_route.final_result = !i_in.last_byte;
        if (w_pbytes > w_fam) begin
            w_route.kind        = KIND_DROPPED;
            w_route.prefix_high = '0;
            w_route.prefix_low  = '0;
        end else begin
            w_route.kind        = i_in.is_update ? KIND_ANNOUNCE : KIND_WITHDRAW;
            w_route.prefix_high = w_pfx_wide[127:64];
            w_route.prefix_low  = w_pfx_wide[63:0];
        end

        // entry finished: drop back to expecting a length byte
        if (w_done) begin
            n_phase = PH_LEN;
            n_len   = '0;
            n_seen  = '0;
        end

        w_status.route_label  = '0;
        w_status.prefix_bits  = '0;
        w_status.prefix_high  = '0;
        w_status.prefix_low   = '0;
        w_status.final_result = 1'b1;
        case (n_err)
            ERR_SHORT:   w_status.kind = KIND_SHORT;
            ERR_IGNORED: w_status.kind = KIND_IGNORED;
            default:     w_status.kind = (n_phase == PH_BODY) ? KIND_OVERRUN
                                                              : KIND_PACKET_OK;
        endcase

        if (i_in.last_byte) begin
            n_err   = ERR_NONE;
            n_phase = PH_LEN;
            n_len   = '0;
            n_seen  = '0;
        end

        w_res0     = w_done ? w_route : w_status;
        w_res1     = w_status;
        w_push_cnt = w_take ? (2'(w_done) + 2'(i_in.last_byte)) : 2'd0;
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_label <= n_label;
            r_pfx   <= n_pfx;
        end
        if (!i_rst_n) begin
            r_af    <= 1'b0;
            r_sess  <= 1'b0;
            r_phase <= PH_LEN;
            r_err   <= ERR_NONE;
            r_len   <= '0;
            r_seen  <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_ADDR_FAMILY: r_af   <= i_cfg_data;
                    CFG_SESSION:     r_sess <= i_cfg_data;
                    default:         ;
                endcase
            end
            // advance the parse state on each accepted beat
            if (w_take) begin
                r_phase <= n_phase;
                r_err   <= n_err;
                r_len   <= n_len;
                r_seen  <= n_seen;
            end
        end
    end

    lunp_res_q u_res_q (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push_cnt  (w_push_cnt),
        .i_res0      (w_res0),
        .i_res1      (w_res1),
        .o_can_take  (w_can_take),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

endmodule

@@ hw/rtl/lunp_checker.sv @@
module lunp_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input lunp_pkg::t_out_beat o_out
);
    import lunp_pkg::*;

    logic w_status;
    assign w_status = (o_out.kind == KIND_PACKET_OK) || (o_out.kind == KIND_SHORT) ||
                      (o_out.kind == KIND_OVERRUN) || (o_out.kind == KIND_IGNORED);

    // a stalled beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("stalled result beat changed");

    // reset empties the result queue
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result offered after reset");

    // packet status always closes the results of its byte and carries no route
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && w_status |-> o_out.final_result && o_out.route_label == '0 &&
        o_out.prefix_bits == '0 && o_out.prefix_high == '0 && o_out.prefix_low == '0)
        else $error("malformed status beat");

    // dropped entries carry no prefix
    a_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.kind == KIND_DROPPED |->
        o_out.prefix_high == '0 && o_out.prefix_low == '0)
        else $error("dropped entry carries a prefix");

    // an empty queue never stalls the input
    a_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled with empty result queue");

endmodule

bind labeled_unicast_nlri_parser_core lunp_checker u_lunp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);

@@ test/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import lunp_pkg::*;

    localparam int unsigned PFX_MAX     = 16;
    localparam int          CYCLE_LIMIT = 400000;
    localparam int          PRESS_AT    = 300;  // bytes taken before the long hold-off
    localparam int          PRESS_LEN   = 160;  // cycles the receiver holds off for
    localparam int          DRAIN_WAIT  = 4;    // cycles after the last result before a write

    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;

    // Input channel
    logic       in_valid     = 1'b0;
    t_in_beat   nlri_beat    = '0;
    logic       o_in_stall;

    // Output channel
    logic       o_out_valid;
    t_out_beat  o_out;
    logic       rx_stall     = 1'b0;
    int         press_left   = 0;
    bit         press_armed  = 1'b1;
    wire        out_stall    = rx_stall || (press_left != 0);

    // Configuration channel
    logic       cfg_valid    = 1'b0;
    logic       cfg_index    = 1'b0;
    logic       cfg_data     = 1'b0;
    logic       o_cfg_ready;

    // Stimulus and scoreboard
    t_in_beat   tx_bytes[$];
    t_out_beat  due_results[$];
    int         n_pushed     = 0;
    int         n_taken      = 0;
    int         n_fail       = 0;
    int         tx_gap       = 0;
    int         rx_wait      = 0;
    int         cycles       = 0;
    bit         tx_quiet     = 1'b0;
    bit         rx_quiet     = 1'b0;

    // Predictor copy of the registers and of the parse state
    logic        fam_cfg;
    logic        sess_cfg;
    t_phase      p_phase;
    logic [7:0]  p_len;
    logic [5:0]  p_seen;
    logic [23:0] p_label;
    logic [127:0] p_prefix;
    t_err        p_err;

    labeled_unicast_nlri_parser_core #(
        .MAX_PREFIX_BYTES(PFX_MAX)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (nlri_beat),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out       (o_out),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Drop the entry being assembled and go back to expecting a length byte.
    function automatic void clear_parse();
        p_phase  = PH_LEN;
        p_len    = '0;
        p_seen   = '0;
        p_label  = '0;
        p_prefix = '0;
    endfunction

    function automatic t_out_beat make_result(t_kind kind, logic [23:0] lbl,
                                              logic [7:0] bits, logic [63:0] hi,
                                              logic [63:0] lo);
        t_out_beat r;
        r.kind         = kind;
        r.route_label  = lbl;
        r.prefix_bits  = bits;
        r.prefix_high  = hi;
        r.prefix_low   = lo;
        r.final_result = 1'b0;
        return r;
    endfunction

    // Advance the parse by one accepted NLRI byte and queue the beats it must cause:
    // a route or drop report when the byte completes an entry, then the packet
    // status when it is the last byte.
    function automatic void parse_nlri_byte(t_in_beat beat);
        int unsigned psize;
        int unsigned k;
        int unsigned pidx;
        int unsigned lim;
        t_out_beat   entry_res;
        bit          have_entry;
        t_kind       status;
        have_entry = 1'b0;

        // A byte arriving with the session down poisons the rest of the packet,
        // unless a short length has already done so.
        if (!sess_cfg && p_err == ERR_NONE)
            p_err = ERR_IGNORED;

        if (p_err == ERR_NONE) begin
            if (p_phase == PH_LEN) begin
                if (beat.data_byte < LABEL_BITS) begin
                    p_err = ERR_SHORT;
                end else begin
                    clear_parse();
                    p_len   = beat.data_byte;
                    p_phase = PH_BODY;
                end
            end else begin
                psize = (int'(p_len) + 7) >> 3;
                k     = p_seen;
                if (k < LABEL_BYTES) begin
                    p_label = {p_label[15:0], beat.data_byte};
                end else begin
                    // Keep prefix bytes left-aligned; bytes past the buffer are lost.
                    pidx = k - LABEL_BYTES;
                    if (pidx < 16 && pidx < PFX_MAX)
                        p_prefix[127 - 8 * pidx -: 8] = beat.data_byte;
                end
                p_seen = 6'(k + 1);
                if (k + 1 >= psize) begin
                    lim = fam_cfg ? 16 : IPV4_BYTES;
                    if (lim > PFX_MAX)
                        lim = PFX_MAX;
                    have_entry = 1'b1;
                    if (psize - LABEL_BYTES > lim)
                        entry_res = make_result(KIND_DROPPED, p_label, p_len - LABEL_BITS,
                                                '0, '0);
                    else
                        entry_res = make_result(beat.is_update ? KIND_ANNOUNCE : KIND_WITHDRAW,
                                                p_label, p_len - LABEL_BITS,
                                                p_prefix[127:64], p_prefix[63:0]);
                    clear_parse();
                end
            end
        end

        if (have_entry) begin
            entry_res.final_result = !beat.last_byte;
            due_results.push_back(entry_res);
        end

        if (beat.last_byte) begin
            if (p_err == ERR_SHORT)
                status = KIND_SHORT;
            else if (p_err == ERR_IGNORED)
                status = KIND_IGNORED;
            else if (p_phase == PH_BODY)
                status = KIND_OVERRUN;
            else
                status = KIND_PACKET_OK;
            entry_res = make_result(status, '0, '0, '0, '0);
            entry_res.final_result = 1'b1;
            due_results.push_back(entry_res);
            p_err = ERR_NONE;
            clear_parse();
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Idle cycles before the next beat; at least half the draws give none at all.
    function automatic int draw_wait(bit quiet);
        if (quiet)
            return 0;
        return $urandom_range(0, 1) ? $urandom_range(0, 11) : 0;
    endfunction

    function automatic void push_byte(logic [7:0] data, logic upd, logic last);
        tx_bytes.push_back('{data_byte: data, is_update: upd, last_byte: last});
        n_pushed++;
    endfunction

    // Build one packet and queue it; return how many bytes it holds.
    // Mostly well-formed entries, some cut short, some pure noise.
    function automatic int push_packet(bit fam6);
        t_in_beat    pkt[$];
        int          mode;
        int          n_ent;
        int          len;
        int          maxp;
        logic        upd;
        upd  = 1'($urandom_range(0, 1));
        mode = $urandom_range(0, 9);
        maxp = fam6 ? 16 : IPV4_BYTES;
        if (mode == 0) begin
            repeat ($urandom_range(1, 12))
                pkt.push_back('{data_byte: 8'($urandom), is_update: upd, last_byte: 1'b0});
        end else begin
            n_ent = $urandom_range(1, 4);
            repeat (n_ent) begin
                case ($urandom_range(0, 9))
                    0:       len = $urandom_range(0, 23);
                    1:       len = $urandom_range(24 + 8 * maxp + 1, 255);
                    2, 3, 4: len = 24 + 8 * maxp;
                    default: len = $urandom_range(24, 24 + 8 * maxp);
                endcase
                pkt.push_back('{data_byte: 8'(len), is_update: upd, last_byte: 1'b0});
                if (len >= 24) begin
                    repeat ((len + 7) / 8)
                        pkt.push_back('{data_byte: 8'($urandom), is_update: upd,
                                        last_byte: 1'b0});
                end
            end
            // Cut the packet somewhere inside, possibly on a length byte.
            if (mode == 1 && pkt.size() > 1) begin
                repeat ($urandom_range(1, pkt.size() - 1))
                    void'(pkt.pop_back());
            end
        end
        pkt[pkt.size() - 1].last_byte = 1'b1;
        foreach (pkt[i])
            push_byte(pkt[i].data_byte, pkt[i].is_update, pkt[i].last_byte);
        return pkt.size();
    endfunction

    task automatic write_reg(input logic idx, input logic val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!o_cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_ADDR_FAMILY)
            fam_cfg = val;
        else
            sess_cfg = val;
        @(posedge clk);
    endtask

    // Hold until every byte is taken and every result is back, then let the
    // pipeline drain of bytes that cause nothing.
    task automatic settle();
        do
            @(posedge clk);
        while (!(n_taken == n_pushed && due_results.size() == 0));
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic run_phase(input logic fam, input logic sess, input int n_bytes,
                             input bit tq, input bit rq);
        int count;
        count = 0;
        write_reg(CFG_ADDR_FAMILY, fam);
        write_reg(CFG_SESSION, sess);
        tx_quiet <= tq;
        rx_quiet <= rq;
        while (count < n_bytes)
            count += push_packet(fam);
        settle();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        fam_cfg  = 1'b0;
        sess_cfg = 1'b0;
        p_err    = ERR_NONE;
        clear_parse();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Session down: a whole packet is ignored.
        write_reg(CFG_ADDR_FAMILY, 1'b0);
        write_reg(CFG_SESSION, 1'b0);
        push_byte(8'd56, 1'b1, 1'b0);
        push_byte(8'h01, 1'b1, 1'b1);
        settle();

        // IPv4, session up.
        write_reg(CFG_SESSION, 1'b1);
        // Withdraw packet: bare label, then a /21 with trailing bits set that
        // completes on the last byte (route then status).
        push_byte(8'd24, 1'b0, 1'b0);
        push_byte(8'h12, 1'b0, 1'b0);
        push_byte(8'h34, 1'b0, 1'b0);
        push_byte(8'h56, 1'b0, 1'b0);
        push_byte(8'd45, 1'b0, 1'b0);
        push_byte(8'h00, 1'b0, 1'b0);
        push_byte(8'h00, 1'b0, 1'b0);
        push_byte(8'h10, 1'b0, 1'b0);
        push_byte(8'hC0, 1'b0, 1'b0);
        push_byte(8'hA8, 1'b0, 1'b0);
        push_byte(8'h81, 1'b0, 1'b1);
        // Five prefix bytes is too long for IPv4: drop it, then a length byte
        // that is itself last leaves the packet overrun.
        push_byte(8'd57, 1'b1, 1'b0);
        repeat (8) push_byte(8'hFF, 1'b1, 1'b0);
        push_byte(8'd33, 1'b1, 1'b1);
        // Announce, then a length below the label size spoils the packet.
        push_byte(8'd24, 1'b1, 1'b0);
        push_byte(8'hAB, 1'b1, 1'b0);
        push_byte(8'hCD, 1'b1, 1'b0);
        push_byte(8'hEF, 1'b1, 1'b0);
        push_byte(8'd10, 1'b1, 1'b0);
        push_byte(8'hFF, 1'b1, 1'b1);
        settle();

        // Random traffic across the settings; the long hold-off lands in the
        // second phase.
        run_phase(1'b0, 1'b1, 140, 1'b0, 1'b0);
        run_phase(1'b1, 1'b1, 220, 1'b0, 1'b0);
        run_phase(1'b1, 1'b0, 30,  1'b0, 1'b0);
        run_phase(1'b0, 1'b1, 140, 1'b1, 1'b1);
        run_phase(1'b1, 1'b1, 170, 1'b1, 1'b0);
        run_phase(1'b0, 1'b1, 100, 1'b0, 1'b1);

        repeat (8) @(posedge clk);
        if (n_fail == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------
    // Driver: offer queued bytes, hold each beat while stalled
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            tx_gap   <= 0;
        end else begin
            if (in_valid && !o_in_stall) begin
                parse_nlri_byte(nlri_beat);
                n_taken <= n_taken + 1;
            end
            if (!in_valid || !o_in_stall) begin
                if (tx_gap != 0) begin
                    in_valid <= 1'b0;
                    tx_gap   <= tx_gap - 1;
                end else if (tx_bytes.size() != 0) begin
                    nlri_beat <= tx_bytes.pop_front();
                    in_valid  <= 1'b1;
                    tx_gap    <= draw_wait(tx_quiet);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: take result beats and compare with the oldest prediction
    // ------------------------------------------------------------------
    function automatic void field_check(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected 'h%0h, got 'h%0h", name, want, got);
            n_fail++;
        end
    endfunction

    function automatic void check_result(t_out_beat got);
        t_out_beat want;
        if (due_results.size() == 0) begin
            $error("kind: expected no result, got %0d", got.kind);
            n_fail++;
            return;
        end
        want = due_results.pop_front();
        field_check("kind",         64'(want.kind),         64'(got.kind));
        field_check("route_label",  64'(want.route_label),  64'(got.route_label));
        field_check("prefix_bits",  64'(want.prefix_bits),  64'(got.prefix_bits));
        field_check("prefix_high",  want.prefix_high,       got.prefix_high);
        field_check("prefix_low",   want.prefix_low,        got.prefix_low);
        field_check("final_result", 64'(want.final_result), 64'(got.final_result));
    endfunction

    always @(posedge clk) begin : rx_side
        int w;
        if (!rst_n) begin
            rx_stall <= 1'b0;
            rx_wait  <= 0;
        end else begin
            if (o_out_valid && !out_stall) begin
                check_result(o_out);
                w = draw_wait(rx_quiet);
            end else begin
                w = (rx_wait != 0) ? rx_wait - 1 : 0;
            end
            rx_wait  <= w;
            rx_stall <= (w != 0);
        end
    end

    // Long receiver hold-off, once, while the sender keeps offering: the result
    // queue fills and the block must stall its input.
    always @(posedge clk) begin
        if (!rst_n) begin
            press_left <= 0;
        end else if (press_armed && n_taken >= PRESS_AT) begin
            press_left  <= PRESS_LEN;
            press_armed <= 1'b0;
        end else if (press_left != 0) begin
            press_left <= press_left - 1;
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

endmodule

@@ files.f @@
hw/rtl/lunp_pkg.sv
hw/rtl/lunp_res_q.sv
hw/rtl/labeled_unicast_nlri_parser_core.sv
hw/rtl/lunp_checker.sv
test/tb_top.sv
